[sv/pbee_pkg.sv]
// shared types, codes and helpers of the pci bus enumeration engine
package pbee_pkg;

	localparam int DEVICES_PER_BUS      = 32;
	localparam int FUNCTIONS_PER_DEVICE = 8;
	localparam int BAR_SLOTS            = 6;
	localparam int RECORD_WORDS         = 9;

	localparam logic [2:0] OP_START      = 3'd0;
	localparam logic [2:0] OP_RESPONSE   = 3'd1;
	localparam logic [2:0] OP_FIND_ID    = 3'd2;
	localparam logic [2:0] OP_FIND_CLASS = 3'd3;
	localparam logic [2:0] OP_GET_INDEX  = 3'd4;

	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_RECORD  = 2'd2;
	localparam logic [1:0] KIND_REJECT  = 2'd3;

	localparam logic [5:0] DW_ID     = 6'd0;
	localparam logic [5:0] DW_CLASS  = 6'd2;
	localparam logic [5:0] DW_HEADER = 6'd3;
	localparam logic [5:0] DW_BAR0   = 6'd4;
	localparam logic [5:0] DW_BUSNUM = 6'd6;
	localparam logic [5:0] DW_IRQ    = 6'd15;

	localparam logic [15:0] ABSENT_VENDOR  = 16'hFFFF;
	localparam logic [7:0]  CLASS_BRIDGE   = 8'h06;
	localparam logic [7:0]  SUBCLASS_P2P   = 8'h04;
	localparam logic [7:0]  BUS_INVALID    = 8'd255;
	localparam logic [6:0]  HDR_TYPE_NORMAL = 7'd0;
	localparam logic [6:0]  HDR_TYPE_BRIDGE = 7'd1;

	typedef enum logic [3:0] {
		W_IDLE, W_ROOT_ID, W_ROOT_HDR, W_MROOT_ID, W_FN_ID,
		W_FN_CLASS, W_FN_HDR, W_FN_IRQ, W_FN_BAR, W_BR_SEC
	} walk_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_BR_RD, S_BR_CMP, S_REC_RD, S_REC_OUT
	} seq_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] read_data;
		logic [15:0] vendor_key;
		logic [15:0] device_key;
		logic [7:0]  class_key;
		logic [7:0]  subclass_key;
		logic [5:0]  entry_request;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  bus;
		logic [4:0]  device_num;
		logic [2:0]  function_num;
		logic [5:0]  dword_index;
		logic [31:0] data_word;
		logic        found;
		logic [5:0]  entry_index;
		logic [6:0]  device_count;
		logic        last;
	} out_t;

	function automatic out_t mk_result(input logic [1:0] kind, input logic [7:0] b,
		input logic [4:0] d, input logic [2:0] f, input logic [5:0] dw);
		out_t r;
		r = '0;
		r.kind = kind;
		r.bus = b;
		r.device_num = d;
		r.function_num = f;
		r.dword_index = dw;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic logic [2:0] bar_total(input logic [7:0] hdr);
		logic [2:0] n;
		if (hdr[6:0] == HDR_TYPE_NORMAL) begin
			n = 3'(BAR_SLOTS);
		end else if (hdr[6:0] == HDR_TYPE_BRIDGE) begin
			n = 3'd2;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

endpackage

[sv/pci_bus_enumeration_engine_core.sv]
// pci configuration space walker with device table and record lookups
//
// The host starts a walk with a start beat; the block answers every beat with
// results: each read response returns the next config read request (or done),
// and a lookup returns a nine-word record or a reject. A walk step is answered
// directly from the idle state, except where the walk moves on to the bridge
// list (a bus scan ends or a bridge bus is skipped): the bridge search then
// reads the table memory entry by entry, through a read state and a compare
// state per entry, and ends with a final check. Lookups by id or class scan the
// table the same way, and a record then goes out word by word, each word paced
// by a read state and an output state on the registered table memory reads.
// The block takes a new beat only when its sequencer is idle and the output
// register is free. Table memories need no clearing after reset.
module pci_bus_enumeration_engine_core import pbee_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int BD = MAX_ENTRIES * BAR_SLOTS;
	localparam int BW = (BD > 1) ? $clog2(BD) : 1;
	localparam logic [3:0] FIRST_BAR_WORD = 4'd3;
	localparam logic [3:0] LAST_WORD = 4'(RECORD_WORDS - 1);

	logic [63:0] ident_mem [MAX_ENTRIES];
	logic [31:0] loc_mem [MAX_ENTRIES];
	logic [31:0] bar_mem [BD];

	seq_t seq_q, seq_d;
	walk_t walk_q, walk_d;
	logic [CW-1:0] count_q, count_d, bp_q, bp_d;
	logic [7:0] bus_q, bus_d;
	logic [4:0] dev_q, dev_d;
	logic [2:0] fn_q, fn_d, bc_q, bc_d;
	logic [3:0] rootf_q, rootf_d, k_q, k_d;
	logic multi_q, multi_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [31:0] wid_q, wid_d;
	logic [23:0] wcls_q, wcls_d;
	logic [7:0] whdr_q, whdr_d;
	in_t key_q, key_d;
	logic mode_q, mode_d;
	logic [63:0] ident_rd_q;
	logic [31:0] loc_rd_q, bar_rd_q;
	logic out_valid_q, out_valid_d;
	out_t out_q, out_d;

	logic out_free, accept, out_load;
	logic id_we, bar_we;
	logic [IW-1:0] slot;
	logic [BW-1:0] bar_waddr, bar_raddr;
	logic [2:0] rec_bars;
	logic [31:0] rec_word;
	logic hit, is_bridge, absent, last_bar;
	logic nf, nfm, nd, bd, ra, br;

	assign slot = IW'(count_q);
	assign absent = in_data.read_data[15:0] == ABSENT_VENDOR;
	assign bar_waddr = (BW'(slot) << 2) + (BW'(slot) << 1) + BW'(bc_q);
	assign bar_raddr = (BW'(idx_q) << 2) + (BW'(idx_q) << 1) + BW'(k_q) - BW'(FIRST_BAR_WORD);
	assign rec_bars = bar_total(ident_rd_q[63:56]);
	assign is_bridge = ident_rd_q[55:48] == CLASS_BRIDGE && ident_rd_q[47:40] == SUBCLASS_P2P;
	assign hit = mode_q ?
		(ident_rd_q[55:48] == key_q.class_key && ident_rd_q[47:40] == key_q.subclass_key) :
		(ident_rd_q[15:0] == key_q.vendor_key && ident_rd_q[31:16] == key_q.device_key);
	assign last_bar = (bc_q + 3'd1) >= bar_total(whdr_q);

	always_comb begin
		unique case (k_q)
			4'd0: rec_word = ident_rd_q[31:0];
			4'd1: rec_word = {ident_rd_q[55:32], ident_rd_q[63:56]};
			4'd2: rec_word = {16'h0000, loc_rd_q[31:16]};
			default: rec_word = ((k_q - FIRST_BAR_WORD) < 4'(rec_bars)) ? bar_rd_q : 32'h0;
		endcase
	end

	// handshake outputs
	always_comb begin
		out_free = !out_valid_q || out_ready;
		in_ready = (seq_q == S_IDLE) && out_free;
		accept = in_valid && in_ready;
		out_valid = out_valid_q;
		out_data = out_q;
	end

	// next state
	always_comb begin
		seq_d = seq_q; walk_d = walk_q; count_d = count_q; bp_d = bp_q;
		bus_d = bus_q; dev_d = dev_q; fn_d = fn_q; bc_d = bc_q; rootf_d = rootf_q;
		k_d = k_q; multi_d = multi_q; idx_d = idx_q; wid_d = wid_q; wcls_d = wcls_q;
		whdr_d = whdr_q; key_d = key_q; mode_d = mode_q;
		out_load = 1'b0; out_d = out_q;
		id_we = 1'b0; bar_we = 1'b0;
		nf = 1'b0; nfm = 1'b0; nd = 1'b0; bd = 1'b0; ra = 1'b0; br = 1'b0;
		unique case (seq_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_data.operation)
						OP_START: begin
							count_d = '0; multi_d = 1'b0; rootf_d = '0; bp_d = '0;
							bc_d = '0; bus_d = '0; dev_d = '0; fn_d = '0;
							walk_d = W_ROOT_ID;
							out_load = 1'b1;
							out_d = mk_result(KIND_REQUEST, 8'd0, 5'd0, 3'd0, DW_ID);
						end
						OP_RESPONSE: begin
							unique case (walk_q)
								W_ROOT_ID: begin
									out_load = 1'b1;
									if (absent) begin
										walk_d = W_IDLE;
										out_d = mk_result(KIND_DONE, 8'd0, 5'd0, 3'd0, 6'd0);
									end else begin
										walk_d = W_ROOT_HDR;
										out_d = mk_result(KIND_REQUEST, 8'd0, 5'd0, 3'd0,
											DW_HEADER);
									end
								end
								W_ROOT_HDR: begin
									multi_d = in_data.read_data[23];
									rootf_d = '0;
									bus_d = '0; dev_d = '0; fn_d = '0;
									walk_d = W_FN_ID;
									out_load = 1'b1;
									out_d = mk_result(KIND_REQUEST, 8'd0, 5'd0, 3'd0, DW_ID);
								end
								W_MROOT_ID: begin
									if (absent) begin
										ra = 1'b1;
									end else begin
										bus_d = 8'(rootf_q); dev_d = '0; fn_d = '0;
										walk_d = W_FN_ID;
										out_load = 1'b1;
										out_d = mk_result(KIND_REQUEST, 8'(rootf_q), 5'd0, 3'd0,
											DW_ID);
									end
								end
								W_FN_ID: begin
									if (absent) begin
										if (fn_q == 3'd0) begin
											nd = 1'b1;
										end else begin
											nf = 1'b1; nfm = 1'b1;
										end
									end else if (count_q == CW'(MAX_ENTRIES)) begin
										walk_d = W_IDLE;
										out_load = 1'b1;
										out_d = mk_result(KIND_DONE, 8'd0, 5'd0, 3'd0, 6'd0);
									end else begin
										wid_d = in_data.read_data;
										walk_d = W_FN_CLASS;
										out_load = 1'b1;
										out_d = mk_result(KIND_REQUEST, bus_q, dev_q, fn_q, DW_CLASS);
									end
								end
								W_FN_CLASS: begin
									wcls_d = in_data.read_data[31:8];
									walk_d = W_FN_HDR;
									out_load = 1'b1;
									out_d = mk_result(KIND_REQUEST, bus_q, dev_q, fn_q, DW_HEADER);
								end
								W_FN_HDR: begin
									whdr_d = in_data.read_data[23:16];
									walk_d = W_FN_IRQ;
									out_load = 1'b1;
									out_d = mk_result(KIND_REQUEST, bus_q, dev_q, fn_q, DW_IRQ);
								end
								W_FN_IRQ: begin
									id_we = 1'b1;
									if (bar_total(whdr_q) == 3'd0) begin
										count_d = count_q + CW'(1);
										nf = 1'b1; nfm = whdr_q[7];
									end else begin
										bc_d = '0;
										walk_d = W_FN_BAR;
										out_load = 1'b1;
										out_d = mk_result(KIND_REQUEST, bus_q, dev_q, fn_q, DW_BAR0);
									end
								end
								W_FN_BAR: begin
									bar_we = 1'b1;
									bc_d = bc_q + 3'd1;
									if (last_bar) begin
										count_d = count_q + CW'(1);
										nf = 1'b1; nfm = whdr_q[7];
									end else begin
										out_load = 1'b1;
										out_d = mk_result(KIND_REQUEST, bus_q, dev_q, fn_q,
											DW_BAR0 + 6'(bc_q) + 6'd1);
									end
								end
								W_BR_SEC: begin
									if (in_data.read_data[15:8] != 8'd0 &&
										in_data.read_data[15:8] != BUS_INVALID) begin
										bus_d = in_data.read_data[15:8]; dev_d = '0; fn_d = '0;
										walk_d = W_FN_ID;
										out_load = 1'b1;
										out_d = mk_result(KIND_REQUEST, in_data.read_data[15:8],
											5'd0, 3'd0, DW_ID);
									end else begin
										bp_d = bp_q + CW'(1);
										br = 1'b1;
									end
								end
								default: begin
									out_load = 1'b1;
									out_d = mk_result(KIND_REJECT, 8'd0, 5'd0, 3'd0, 6'd0);
								end
							endcase
						end
						OP_FIND_ID, OP_FIND_CLASS: begin
							key_d = in_data;
							mode_d = in_data.operation == OP_FIND_CLASS;
							if (count_q == '0) begin
								out_load = 1'b1;
								out_d = mk_result(KIND_REJECT, 8'd0, 5'd0, 3'd0, 6'd0);
							end else begin
								idx_d = '0;
								seq_d = S_SCAN_RD;
							end
						end
						OP_GET_INDEX: begin
							if (9'(in_data.entry_request) < 9'(count_q)) begin
								idx_d = IW'(in_data.entry_request);
								k_d = '0;
								seq_d = S_REC_RD;
							end else begin
								out_load = 1'b1;
								out_d = mk_result(KIND_REJECT, 8'd0, 5'd0, 3'd0, 6'd0);
							end
						end
						default: begin
							out_load = 1'b1;
							out_d = mk_result(KIND_REJECT, 8'd0, 5'd0, 3'd0, 6'd0);
						end
					endcase
				end
			end
			S_SCAN_RD: seq_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				if (hit) begin
					k_d = '0;
					seq_d = S_REC_RD;
				end else if ((CW'(idx_q) + CW'(1)) < count_q) begin
					idx_d = idx_q + IW'(1);
					seq_d = S_SCAN_RD;
				end else if (out_free) begin
					out_load = 1'b1;
					out_d = mk_result(KIND_REJECT, 8'd0, 5'd0, 3'd0, 6'd0);
					seq_d = S_IDLE;
				end
			end
			S_BR_RD: seq_d = S_BR_CMP;
			S_BR_CMP: begin
				if (bp_q < count_q) begin
					if (!is_bridge) begin
						bp_d = bp_q + CW'(1);
						idx_d = IW'(bp_q + CW'(1));
						seq_d = S_BR_RD;
					end else if (out_free) begin
						walk_d = W_BR_SEC;
						out_load = 1'b1;
						out_d = mk_result(KIND_REQUEST, loc_rd_q[7:0], loc_rd_q[12:8],
							loc_rd_q[15:13], DW_BUSNUM);
						seq_d = S_IDLE;
					end
				end else if (out_free) begin
					walk_d = W_IDLE;
					out_load = 1'b1;
					out_d = mk_result(KIND_DONE, 8'd0, 5'd0, 3'd0, 6'd0);
					seq_d = S_IDLE;
				end
			end
			S_REC_RD: seq_d = S_REC_OUT;
			S_REC_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d = mk_result(KIND_RECORD, loc_rd_q[7:0], loc_rd_q[12:8],
						loc_rd_q[15:13], 6'd0);
					out_d.data_word = rec_word;
					out_d.found = 1'b1;
					out_d.entry_index = 6'(idx_q);
					out_d.last = k_q == LAST_WORD;
					k_d = k_q + 4'd1;
					seq_d = (k_q == LAST_WORD) ? S_IDLE : S_REC_RD;
				end
			end
			default: seq_d = S_IDLE;
		endcase

		// walk advance chain
		if (nf) begin
			if ((fn_q == 3'd0 && !nfm) || fn_q == 3'(FUNCTIONS_PER_DEVICE - 1)) begin
				nd = 1'b1;
			end else begin
				fn_d = fn_q + 3'd1;
				walk_d = W_FN_ID;
				out_load = 1'b1;
				out_d = mk_result(KIND_REQUEST, bus_q, dev_q, fn_q + 3'd1, DW_ID);
			end
		end
		if (nd) begin
			fn_d = '0;
			dev_d = dev_q + 5'd1;
			if (dev_q == 5'(DEVICES_PER_BUS - 1)) begin
				bd = 1'b1;
			end else begin
				walk_d = W_FN_ID;
				out_load = 1'b1;
				out_d = mk_result(KIND_REQUEST, bus_q, dev_q + 5'd1, 3'd0, DW_ID);
			end
		end
		if (bd) begin
			if (rootf_q < 4'(FUNCTIONS_PER_DEVICE)) begin
				if (multi_q) begin
					ra = 1'b1;
				end else begin
					rootf_d = 4'(FUNCTIONS_PER_DEVICE);
					bp_d = '0;
					br = 1'b1;
				end
			end else begin
				bp_d = bp_q + CW'(1);
				br = 1'b1;
			end
		end
		if (ra) begin
			rootf_d = rootf_q + 4'd1;
			if ((rootf_q + 4'd1) < 4'(FUNCTIONS_PER_DEVICE)) begin
				walk_d = W_MROOT_ID;
				out_load = 1'b1;
				out_d = mk_result(KIND_REQUEST, 8'd0, 5'd0, 3'(rootf_q + 4'd1), DW_ID);
			end else begin
				bp_d = '0;
				br = 1'b1;
			end
		end
		if (br) begin
			idx_d = IW'(bp_d);
			seq_d = S_BR_RD;
		end

		out_d.device_count = 7'(count_d);
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			walk_q <= W_IDLE;
			count_q <= '0;
			bp_q <= '0;
			bus_q <= '0;
			dev_q <= '0;
			fn_q <= '0;
			bc_q <= '0;
			rootf_q <= '0;
			k_q <= '0;
			multi_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			walk_q <= walk_d;
			count_q <= count_d;
			bp_q <= bp_d;
			bus_q <= bus_d;
			dev_q <= dev_d;
			fn_q <= fn_d;
			bc_q <= bc_d;
			rootf_q <= rootf_d;
			k_q <= k_d;
			multi_q <= multi_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		wid_q <= wid_d;
		wcls_q <= wcls_d;
		whdr_q <= whdr_d;
		key_q <= key_d;
		mode_q <= mode_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (id_we) begin
			ident_mem[slot] <= {whdr_q, wcls_q, wid_q};
			loc_mem[slot] <= {in_data.read_data[15:0], fn_q, dev_q, bus_q};
		end
		ident_rd_q <= ident_mem[idx_q];
		loc_rd_q <= loc_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (bar_we) begin
			bar_mem[bar_waddr] <= in_data.read_data;
		end
		bar_rd_q <= bar_mem[bar_raddr];
	end

endmodule
